// ----- hw/rtl/lwps_pkg.sv -----
package lwps_pkg;

    localparam int COORD_BITS  = 10;
    localparam int PANEL_BITS  = 10;
    localparam int OFFSET_BITS = 8;
    localparam int ADDR_BITS   = 16;
    localparam int COLOR_BITS  = 16;
    localparam int PIXEL_BITS  = 20;
    localparam int BYTE_BITS   = 8;
    localparam int STATUS_BITS = 2;

    // Bounds checks run one bit wider than the widest operand.
    localparam int CMP_BITS = ((COORD_BITS > PANEL_BITS) ? COORD_BITS : PANEL_BITS) + 1;
    localparam int AREA_BITS = 2 * COORD_BITS;

    localparam int S_DATA_BITS = 4 * COORD_BITS + COLOR_BITS;
    localparam int S_TDATA_BITS = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = 16;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = PANEL_BITS;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_INDEX_BITS-1:0] REG_X_OFFSET     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_Y_OFFSET     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SWAP_AXES    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PANEL_WIDTH  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PANEL_HEIGHT = 3'd4;

    localparam logic [PANEL_BITS-1:0] PANEL_WIDTH_RESET  = 10'd240;
    localparam logic [PANEL_BITS-1:0] PANEL_HEIGHT_RESET = 10'd320;

    localparam logic [BYTE_BITS-1:0] CMD_CASET = 8'h2A;
    localparam logic [BYTE_BITS-1:0] CMD_RASET = 8'h2B;
    localparam logic [BYTE_BITS-1:0] CMD_RAMWR = 8'h2C;

    localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_BAD_WIN   = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_NO_WINDOW = 2'd2;

    localparam logic KIND_WINDOW = 1'b0;
    localparam logic KIND_PIXEL  = 1'b1;

    typedef enum logic [1:0] {
        JOB_WINDOW,
        JOB_PIXEL,
        JOB_BAD_WINDOW,
        JOB_NO_WINDOW
    } job_kind_t;

    typedef struct packed {
        job_kind_t              kind;
        logic                   done;
        logic [ADDR_BITS-1:0]   col_first;
        logic [ADDR_BITS-1:0]   col_last;
        logic [ADDR_BITS-1:0]   row_first;
        logic [ADDR_BITS-1:0]   row_last;
        logic [COLOR_BITS-1:0]  color;
    } job_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic empty;
    } queue_ctrl_t;

endpackage

// ----- hw/rtl/lcd_window_pixel_serializer.sv -----
// Window pixel serializer for a serial display controller.
// The input stream carries window requests (s_tuser low) and pixel requests
// (s_tuser high). A window request is checked against the panel size; a good
// one yields eleven bytes: the column address command and four address bytes,
// the row address command and four address bytes, and the memory write
// command. Each pixel request yields its high and low color bytes. A rejected
// window or a pixel with no open window yields one status byte that is not
// meant for the link. m_tuser is high on data bytes, m_tlast ends the bytes of
// one request, and the last pixel of a window carries the area-done flag.
// The configuration channel writes offsets, axis swap and panel size; it is
// always ready and must only be used while the block is idle.
// The first byte of a request passes through the queue, the current-job
// register and the output register. The output port moves one byte per
// cycle while the receiver is ready; a four-entry request queue lets the
// input side run ahead of the byte stream. When the receiver stalls, the
// output register holds and the queue fills until s_tready drops. Synchronous
// reset closes any open window, empties the queue and restores the register
// defaults (panel 240 by 320).
module lcd_window_pixel_serializer (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // x [9:0], y [19:10], width [29:20], height [39:30], color [55:40]
    input  logic [lwps_pkg::S_TDATA_BITS-1:0]    s_tdata,
    // kind
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // out_byte [7:0], area_done [8], status [10:9], zero fill above
    output logic [lwps_pkg::M_TDATA_BITS-1:0]    m_tdata,
    // is_data
    output logic                                 m_tuser,
    output logic                                 m_tlast,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lwps_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [lwps_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import lwps_pkg::*;

    job_t        front_job;
    job_t        head_job;
    queue_ctrl_t q_req;
    queue_ctrl_t q_stat;
    logic        in_accept;
    logic        back_pop;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_stat.full;
    assign in_accept = s_tvalid && s_tready;

    assign q_req.push  = in_accept;
    assign q_req.pop   = back_pop;
    assign q_req.full  = 1'b0;
    assign q_req.empty = 1'b0;

    lwps_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_accept (in_accept),
        .in_kind   (s_tuser),
        .in_data   (s_tdata),
        .job       (front_job)
    );

    lwps_fifo u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl_in  (q_req),
        .ctrl_out (q_stat),
        .wr_job   (front_job),
        .rd_job   (head_job)
    );

    lwps_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_job    (head_job),
        .queue_empty (q_stat.empty),
        .queue_pop   (back_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

// ----- hw/rtl/lwps_front.sv -----
module lwps_front (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    input  logic [lwps_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [lwps_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                  in_accept,
    input  logic                                  in_kind,
    input  logic [lwps_pkg::S_TDATA_BITS-1:0]     in_data,
    output lwps_pkg::job_t                        job
);
    import lwps_pkg::*;

    logic [OFFSET_BITS-1:0] x_offset_reg;
    logic [OFFSET_BITS-1:0] y_offset_reg;
    logic                   swap_axes_reg;
    logic [PANEL_BITS-1:0]  panel_width_reg;
    logic [PANEL_BITS-1:0]  panel_height_reg;

    logic                   window_open_reg;
    logic                   window_open_next;
    logic [PIXEL_BITS-1:0]  pixels_left_reg;
    logic [PIXEL_BITS-1:0]  pixels_left_next;

    logic [COORD_BITS-1:0]  x;
    logic [COORD_BITS-1:0]  y;
    logic [COORD_BITS-1:0]  w;
    logic [COORD_BITS-1:0]  h;
    logic [COLOR_BITS-1:0]  color;
    logic [CMP_BITS-1:0]    x_end;
    logic [CMP_BITS-1:0]    y_end;
    logic [CMP_BITS-1:0]    pw_ext;
    logic [CMP_BITS-1:0]    ph_ext;
    logic                   bad_window;
    logic [OFFSET_BITS-1:0] col_off;
    logic [OFFSET_BITS-1:0] row_off;
    logic [AREA_BITS-1:0]   area;
    logic [PIXEL_BITS-1:0]  pixels_dec;

    assign x     = in_data[COORD_BITS-1:0];
    assign y     = in_data[2*COORD_BITS-1:COORD_BITS];
    assign w     = in_data[3*COORD_BITS-1:2*COORD_BITS];
    assign h     = in_data[4*COORD_BITS-1:3*COORD_BITS];
    assign color = in_data[4*COORD_BITS+COLOR_BITS-1:4*COORD_BITS];

    // With the origin inside the panel, width > panel - x is the same as x + width > panel.
    assign pw_ext = CMP_BITS'(panel_width_reg);
    assign ph_ext = CMP_BITS'(panel_height_reg);
    assign x_end  = CMP_BITS'(x) + CMP_BITS'(w);
    assign y_end  = CMP_BITS'(y) + CMP_BITS'(h);

    assign bad_window = (w == '0) || (h == '0) ||
                        (CMP_BITS'(x) >= pw_ext) || (CMP_BITS'(y) >= ph_ext) ||
                        (x_end > pw_ext) || (y_end > ph_ext);

    assign col_off = swap_axes_reg ? y_offset_reg : x_offset_reg;
    assign row_off = swap_axes_reg ? x_offset_reg : y_offset_reg;

    assign area       = w * h;
    assign pixels_dec = pixels_left_reg - PIXEL_BITS'(1);

    always_comb begin
        window_open_next = window_open_reg;
        pixels_left_next = pixels_left_reg;

        job.kind      = JOB_NO_WINDOW;
        job.done      = 1'b0;
        job.col_first = ADDR_BITS'(x) + ADDR_BITS'(col_off);
        job.col_last  = ADDR_BITS'(x) + ADDR_BITS'(w) - ADDR_BITS'(1) + ADDR_BITS'(col_off);
        job.row_first = ADDR_BITS'(y) + ADDR_BITS'(row_off);
        job.row_last  = ADDR_BITS'(y) + ADDR_BITS'(h) - ADDR_BITS'(1) + ADDR_BITS'(row_off);
        job.color     = color;

        if (in_kind == KIND_WINDOW) begin
            if (bad_window) begin
                job.kind = JOB_BAD_WINDOW;
            end else begin
                job.kind = JOB_WINDOW;
                window_open_next = 1'b1;
                pixels_left_next = PIXEL_BITS'(area);
            end
        end else if (window_open_reg) begin
            job.kind = JOB_PIXEL;
            job.done = (pixels_dec == '0);
            pixels_left_next = pixels_dec;
            if (pixels_dec == '0) begin
                window_open_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_open_reg <= 1'b0;
            pixels_left_reg <= '0;
        end else if (in_accept) begin
            window_open_reg <= window_open_next;
            pixels_left_reg <= pixels_left_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_offset_reg     <= '0;
            y_offset_reg     <= '0;
            swap_axes_reg    <= 1'b0;
            panel_width_reg  <= PANEL_WIDTH_RESET;
            panel_height_reg <= PANEL_HEIGHT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_X_OFFSET:     x_offset_reg     <= cfg_data[OFFSET_BITS-1:0];
                REG_Y_OFFSET:     y_offset_reg     <= cfg_data[OFFSET_BITS-1:0];
                REG_SWAP_AXES:    swap_axes_reg    <= cfg_data[0];
                REG_PANEL_WIDTH:  panel_width_reg  <= cfg_data[PANEL_BITS-1:0];
                REG_PANEL_HEIGHT: panel_height_reg <= cfg_data[PANEL_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/lwps_fifo.sv -----
module lwps_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lwps_pkg::queue_ctrl_t ctrl_in,
    output lwps_pkg::queue_ctrl_t ctrl_out,
    input  lwps_pkg::job_t        wr_job,
    output lwps_pkg::job_t        rd_job
);
    import lwps_pkg::*;

    localparam int PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

    job_t                  entries_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  do_push;
    logic                  do_pop;

    assign ctrl_out.push  = do_push;
    assign ctrl_out.pop   = do_pop;
    assign ctrl_out.full  = (count_reg == COUNT_BITS'(QUEUE_DEPTH));
    assign ctrl_out.empty = (count_reg == '0);

    assign do_push = ctrl_in.push && !ctrl_out.full;
    assign do_pop  = ctrl_in.pop && !ctrl_out.empty;

    assign rd_job = entries_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + COUNT_BITS'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - COUNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + PTR_BITS'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + PTR_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

// ----- hw/rtl/lwps_back.sv -----
module lwps_back (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  lwps_pkg::job_t                       head_job,
    input  logic                                 queue_empty,
    output logic                                 queue_pop,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [lwps_pkg::M_TDATA_BITS-1:0]    m_tdata,
    output logic                                 m_tuser,
    output logic                                 m_tlast
);
    import lwps_pkg::*;

    job_t                   cur_reg;
    job_t                   cur_next;
    logic                   cur_valid_reg;
    logic                   cur_valid_next;
    logic [3:0]             idx_reg;
    logic [3:0]             idx_next;

    logic                   out_valid_reg;
    logic [BYTE_BITS-1:0]   out_byte_reg;
    logic                   out_data_reg;
    logic                   out_last_reg;
    logic                   out_done_reg;
    logic [STATUS_BITS-1:0] out_status_reg;

    logic                   load_ok;
    logic                   emit;
    logic                   take;
    logic [BYTE_BITS-1:0]   b_byte;
    logic                   b_data;
    logic                   b_last;
    logic                   b_done;
    logic [STATUS_BITS-1:0] b_status;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = M_TDATA_BITS'({out_status_reg, out_done_reg, out_byte_reg});

    // Byte selection for the current job; b_last marks its final byte.
    always_comb begin
        b_byte   = '0;
        b_data   = 1'b0;
        b_last   = 1'b0;
        b_done   = 1'b0;
        b_status = STATUS_OK;
        unique case (cur_reg.kind)
            JOB_WINDOW: begin
                b_data = 1'b1;
                case (idx_reg)
                    4'd0: begin
                        b_byte = CMD_CASET;
                        b_data = 1'b0;
                    end
                    4'd1: b_byte = cur_reg.col_first[15:8];
                    4'd2: b_byte = cur_reg.col_first[7:0];
                    4'd3: b_byte = cur_reg.col_last[15:8];
                    4'd4: b_byte = cur_reg.col_last[7:0];
                    4'd5: begin
                        b_byte = CMD_RASET;
                        b_data = 1'b0;
                    end
                    4'd6: b_byte = cur_reg.row_first[15:8];
                    4'd7: b_byte = cur_reg.row_first[7:0];
                    4'd8: b_byte = cur_reg.row_last[15:8];
                    4'd9: b_byte = cur_reg.row_last[7:0];
                    default: begin
                        b_byte = CMD_RAMWR;
                        b_data = 1'b0;
                        b_last = 1'b1;
                    end
                endcase
            end
            JOB_PIXEL: begin
                b_data = 1'b1;
                if (idx_reg == 4'd0) begin
                    b_byte = cur_reg.color[15:8];
                end else begin
                    b_byte = cur_reg.color[7:0];
                    b_last = 1'b1;
                    b_done = cur_reg.done;
                end
            end
            JOB_BAD_WINDOW: begin
                b_last   = 1'b1;
                b_status = STATUS_BAD_WIN;
            end
            default: begin
                b_last   = 1'b1;
                b_status = STATUS_NO_WINDOW;
            end
        endcase
    end

    assign load_ok   = !out_valid_reg || m_tready;
    assign emit      = load_ok && cur_valid_reg;
    assign take      = (!cur_valid_reg || (emit && b_last)) && !queue_empty;
    assign queue_pop = take;

    always_comb begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (take) begin
            cur_next       = head_job;
            cur_valid_next = 1'b1;
            idx_next       = '0;
        end else if (emit) begin
            if (b_last) begin
                cur_valid_next = 1'b0;
            end
            idx_next = idx_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        if (emit) begin
            out_byte_reg   <= b_byte;
            out_data_reg   <= b_data;
            out_last_reg   <= b_last;
            out_done_reg   <= b_done;
            out_status_reg <= b_status;
        end
    end

endmodule

// ----- hw/rtl/lwps_checker.sv -----
module lwps_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [lwps_pkg::M_TDATA_BITS-1:0]   m_tdata,
    input logic                                m_tuser,
    input logic                                m_tlast
);
    import lwps_pkg::*;

    // A stalled output keeps its byte and flags.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                                  $stable(m_tuser) && $stable(m_tlast))
        else $error("output changed while stalled");

    // Reset leaves the output channel empty.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // The input side can only fill up when a request is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready && !s_tvalid |=> s_tready)
        else $error("input stalled without a new request");

    // An error status is a lone zero command byte that ends its request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[10:9] != STATUS_OK) |->
            m_tlast && !m_tuser && (m_tdata[7:0] == '0) && !m_tdata[8])
        else $error("malformed error status byte");

    // Area done only marks the final data byte of a pixel.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8] |-> m_tlast && m_tuser && (m_tdata[10:9] == STATUS_OK))
        else $error("area done on the wrong byte");

endmodule

bind lcd_window_pixel_serializer lwps_checker u_lwps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
